// File: rtl/lcdseq_pkg.sv
// ============================================================================
// lcdseq_pkg
// Shared types, codes and the power-up event table for the 4-bit LCD
// bus sequencer.
// ============================================================================
package lcdseq_pkg;

    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Request kinds.
    localparam logic [1:0] FUNC_NIBBLE = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_DATA   = 2'd2;
    localparam logic [1:0] FUNC_INIT   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_DELAY  = 2'd1;

    localparam logic [7:0]  PULSE_WIDTH_RESET = 8'd1;
    localparam logic [15:0] CHAR_DELAY_RESET  = 16'd53;

    // Last event index of each request kind.
    localparam logic [IDX_W-1:0] LAST_IDX_NIBBLE = 5'd1;
    localparam logic [IDX_W-1:0] LAST_IDX_BYTE   = 5'd3;
    localparam logic [IDX_W-1:0] LAST_IDX_INIT   = 5'd28;

    localparam logic [15:0] WAIT_POWERUP = 16'd15000;
    localparam logic [15:0] WAIT_FIRST   = 16'd4100;
    localparam logic [15:0] WAIT_NIBBLE  = 16'd100;
    localparam logic [15:0] WAIT_SHORT   = 16'd53;
    localparam logic [15:0] WAIT_CLEAR   = 16'd3000;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic             load;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_event;
        logic slot_free;
    } dp_status_t;

    typedef struct packed {
        logic        use_held;
        logic [3:0]  nib;
        logic        en;
        logic [15:0] hold;
    } init_ev_t;

    function automatic init_ev_t mk_ev(logic use_held, logic [3:0] nib, logic en,
                                       logic [15:0] hold);
        init_ev_t ev;
        ev.use_held = use_held;
        ev.nib      = nib;
        ev.en       = en;
        ev.hold     = hold;
        return ev;
    endfunction

    // Power-up sequence, one entry per pin event. Enable-high entries take
    // their hold from the pulse width register.
    function automatic init_ev_t init_event(logic [IDX_W-1:0] idx);
        init_ev_t ev;
        case (idx)
            5'd0:    ev = mk_ev(1'b1, 4'h0, 1'b0, WAIT_POWERUP);
            5'd1:    ev = mk_ev(1'b0, 4'h3, 1'b1, 16'd0);
            5'd2:    ev = mk_ev(1'b0, 4'h3, 1'b0, WAIT_FIRST);
            5'd3:    ev = mk_ev(1'b0, 4'h3, 1'b1, 16'd0);
            5'd4:    ev = mk_ev(1'b0, 4'h3, 1'b0, WAIT_NIBBLE);
            5'd5:    ev = mk_ev(1'b0, 4'h3, 1'b1, 16'd0);
            5'd6:    ev = mk_ev(1'b0, 4'h3, 1'b0, WAIT_NIBBLE);
            5'd7:    ev = mk_ev(1'b0, 4'h2, 1'b1, 16'd0);
            5'd8:    ev = mk_ev(1'b0, 4'h2, 1'b0, WAIT_NIBBLE);
            // Function set, 0x28.
            5'd9:    ev = mk_ev(1'b0, 4'h2, 1'b1, 16'd0);
            5'd10:   ev = mk_ev(1'b0, 4'h2, 1'b0, 16'd0);
            5'd11:   ev = mk_ev(1'b0, 4'h8, 1'b1, 16'd0);
            5'd12:   ev = mk_ev(1'b0, 4'h8, 1'b0, WAIT_SHORT);
            // Display off, 0x08.
            5'd13:   ev = mk_ev(1'b0, 4'h0, 1'b1, 16'd0);
            5'd14:   ev = mk_ev(1'b0, 4'h0, 1'b0, 16'd0);
            5'd15:   ev = mk_ev(1'b0, 4'h8, 1'b1, 16'd0);
            5'd16:   ev = mk_ev(1'b0, 4'h8, 1'b0, WAIT_SHORT);
            // Clear display, 0x01.
            5'd17:   ev = mk_ev(1'b0, 4'h0, 1'b1, 16'd0);
            5'd18:   ev = mk_ev(1'b0, 4'h0, 1'b0, 16'd0);
            5'd19:   ev = mk_ev(1'b0, 4'h1, 1'b1, 16'd0);
            5'd20:   ev = mk_ev(1'b0, 4'h1, 1'b0, WAIT_CLEAR);
            // Entry mode, 0x06.
            5'd21:   ev = mk_ev(1'b0, 4'h0, 1'b1, 16'd0);
            5'd22:   ev = mk_ev(1'b0, 4'h0, 1'b0, 16'd0);
            5'd23:   ev = mk_ev(1'b0, 4'h6, 1'b1, 16'd0);
            5'd24:   ev = mk_ev(1'b0, 4'h6, 1'b0, WAIT_SHORT);
            // Display on, 0x0C.
            5'd25:   ev = mk_ev(1'b0, 4'h0, 1'b1, 16'd0);
            5'd26:   ev = mk_ev(1'b0, 4'h0, 1'b0, 16'd0);
            5'd27:   ev = mk_ev(1'b0, 4'hC, 1'b1, 16'd0);
            5'd28:   ev = mk_ev(1'b0, 4'hC, 1'b0, WAIT_SHORT);
            default: ev = mk_ev(1'b0, 4'h0, 1'b0, 16'd0);
        endcase
        return ev;
    endfunction

endpackage

// File: rtl/lcdseq_ctrl.sv
// ============================================================================
// lcdseq_ctrl
// Request state machine and event counter for the LCD bus sequencer.
// ============================================================================
module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             emit;
    logic             load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Outputs: an event goes out whenever a request is running and the
    // output slot can take it. A new request is taken while idle or on the final event.
    always_comb
    begin
        emit     = (state_reg == ST_RUN) && status.slot_free;
        in_ready = (state_reg == ST_IDLE) || (emit && status.last_event);
        load     = in_valid && in_ready;
        cmd.load = load;
        cmd.emit = emit;
        cmd.idx  = idx_reg;
    end

    // Next state and event index.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (load)
                begin
                    idx_next = '0;
                end
                else if (emit && status.last_event)
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
                else if (emit)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

endmodule

// File: rtl/lcdseq_dp.sv
// ============================================================================
// lcdseq_dp
// Datapath: request and configuration registers, event builder, held pin
// levels and the output register.
// ============================================================================
module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            func,
    input  logic [7:0]            value,
    input  logic [15:0]           delay_us,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            nibble,
    output logic                  rs,
    output logic                  enable,
    output logic [15:0]           hold_us,
    output logic                  last
);

    logic [7:0]  pulse_reg;
    logic [15:0] char_delay_reg;
    logic [1:0]  func_reg;
    logic [7:0]  value_reg;
    logic [15:0] delay_reg;
    logic [3:0]  held_nib_reg;
    logic        held_rs_reg;

    logic        out_valid_reg;
    logic [3:0]  nib_out_reg;
    logic        rs_out_reg;
    logic        en_out_reg;
    logic [15:0] hold_out_reg;
    logic        last_out_reg;

    init_ev_t    iev;
    logic [3:0]  ev_nib;
    logic        ev_rs;
    logic        ev_en;
    logic [15:0] ev_hold;
    logic        ev_last;
    logic [15:0] final_wait;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg      <= PULSE_WIDTH_RESET;
            char_delay_reg <= CHAR_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PULSE_WIDTH)
            begin
                pulse_reg <= cfg_wdata[7:0];
            end
            else if (cfg_index == REG_CHAR_DELAY)
            begin
                char_delay_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= value;
            delay_reg <= delay_us;
        end
    end

    // Build the pin event for the current index.
    always_comb
    begin
        iev        = init_event(cmd.idx);
        final_wait = (func_reg == FUNC_DATA) ? char_delay_reg : delay_reg;
        ev_en      = ~cmd.idx[0];
        ev_rs      = 1'b0;
        ev_nib     = value_reg[3:0];
        ev_hold    = ev_en ? {8'd0, pulse_reg} : final_wait;
        ev_last    = 1'b0;
        case (func_reg)
            FUNC_NIBBLE:
            begin
                ev_last = (cmd.idx == LAST_IDX_NIBBLE);
            end
            FUNC_BYTE, FUNC_DATA:
            begin
                ev_rs   = (func_reg == FUNC_DATA);
                ev_nib  = cmd.idx[1] ? value_reg[3:0] : value_reg[7:4];
                ev_last = (cmd.idx == LAST_IDX_BYTE);
                // The enable-low event between the two nibbles holds for zero.
                if (!ev_en && !cmd.idx[1])
                begin
                    ev_hold = 16'd0;
                end
            end
            default:
            begin
                ev_en   = iev.en;
                ev_nib  = iev.use_held ? held_nib_reg : iev.nib;
                ev_rs   = iev.use_held ? held_rs_reg : 1'b0;
                ev_hold = iev.en ? {8'd0, pulse_reg} : iev.hold;
                ev_last = (cmd.idx == LAST_IDX_INIT);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_nib_reg  <= '0;
            held_rs_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            held_nib_reg  <= ev_nib;
            held_rs_reg   <= ev_rs;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            nib_out_reg  <= ev_nib;
            rs_out_reg   <= ev_rs;
            en_out_reg   <= ev_en;
            hold_out_reg <= ev_hold;
            last_out_reg <= ev_last;
        end
    end

    assign status.last_event = ev_last;
    assign status.slot_free  = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign nibble    = nib_out_reg;
    assign rs        = rs_out_reg;
    assign enable    = en_out_reg;
    assign hold_us   = hold_out_reg;
    assign last      = last_out_reg;

endmodule

// File: rtl/lcd_4bit_bus_sequencer_core.sv
// ============================================================================
// lcd_4bit_bus_sequencer_core
// Turns LCD requests (nibble command, byte command, data byte, power-up
// sequence) into a run of 4-bit bus pin events with hold times.
// ============================================================================
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------------
//  in        in_valid / in_ready     func, value, delay_us
//  out       out_valid / out_ready   nibble, rs, enable, hold_us, last
//  cfg       cfg_we (no wait)        cfg_index, cfg_wdata
//
// Each request produces one pin event per clock cycle while the output
// register drains: 2 events for a nibble command, 4 for a byte command or
// data byte, 29 for the power-up sequence. The event counter in the
// controller sets the number of events; the next request is accepted in the
// same cycle as the final event of the current one. A stalled output holds
// the event in the output register and pauses the counter. Reset restores
// the register defaults (pulse width 1 us, character delay 53 us) and
// clears the held pin levels.
//
module lcd_4bit_bus_sequencer_core
    import lcdseq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [7:0]            value,
    input  logic [15:0]           delay_us,
    // Pin event channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            nibble,
    output logic                  rs,
    output logic                  enable,
    output logic [15:0]           hold_us,
    output logic                  last
);

    // The controller walks the event index of the current request; the
    // datapath turns index and request into pin levels and reports when the
    // final event is reached and whether the output register has room.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    lcdseq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lcdseq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .func      (func),
        .value     (value),
        .delay_us  (delay_us),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .nibble    (nibble),
        .rs        (rs),
        .enable    (enable),
        .hold_us   (hold_us),
        .last      (last)
    );

endmodule

// File: tb/lcd_pin_event_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// lcd_pin_event_checker
// Watches the request, pin event and register write ports of the LCD bus
// sequencer, predicts the pin events of every accepted request and compares
// each accepted event with the oldest prediction.
// ============================================================================
module lcd_pin_event_checker
    import lcdseq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [7:0]            value,
    input  logic [15:0]           delay_us,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [3:0]            nibble,
    input  logic                  rs,
    input  logic                  enable,
    input  logic [15:0]           hold_us,
    input  logic                  last,
    output int                    pending_events,
    output int                    mismatch_count
);

    typedef struct packed {
        logic [3:0]  nib;
        logic        sel;
        logic        en;
        logic [15:0] hold;
        logic        fin;
    } pin_event_t;

    // Power-up wait, wake-up nibbles and set-up bytes, first entry in the
    // most significant slice.
    localparam logic [15:0] POWERUP_HOLD = 16'd15000;
    localparam logic [15:0] WAKE_NIBBLES = 16'h3332;
    localparam logic [63:0] WAKE_HOLDS   = {16'd4100, 16'd100, 16'd100, 16'd100};
    localparam logic [39:0] SETUP_BYTES  = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam logic [79:0] SETUP_HOLDS  = {16'd53, 16'd53, 16'd3000, 16'd53, 16'd53};

    pin_event_t  expected_events[$];
    logic [7:0]  pulse_width;
    logic [15:0] char_delay;
    logic [3:0]  held_nibble;
    logic        held_rs;
    int          errors = 0;

    task automatic queue_event(input logic [3:0] nib, input logic sel, input logic en,
                               input logic [15:0] hold, input logic fin);
        pin_event_t ev;
        ev.nib  = nib;
        ev.sel  = sel;
        ev.en   = en;
        ev.hold = hold;
        ev.fin  = fin;
        expected_events.push_back(ev);
        held_nibble = nib;
        held_rs     = sel;
    endtask

    task automatic queue_strobe(input logic [3:0] nib, input logic sel,
                                input logic [15:0] hold, input logic fin);
        queue_event(nib, sel, 1'b1, {8'd0, pulse_width}, 1'b0);
        queue_event(nib, sel, 1'b0, hold, fin);
    endtask

    // The pause between the two halves of a byte is always zero.
    task automatic queue_byte(input logic [7:0] b, input logic sel,
                              input logic [15:0] hold, input logic fin);
        queue_strobe(b[7:4], sel, 16'd0, 1'b0);
        queue_strobe(b[3:0], sel, hold, fin);
    endtask

    task automatic predict_pin_events(input logic [1:0] f, input logic [7:0] v,
                                      input logic [15:0] d);
        int i;
        case (f)
            FUNC_NIBBLE: queue_strobe(v[3:0], 1'b0, d, 1'b1);
            FUNC_BYTE:   queue_byte(v, 1'b0, d, 1'b1);
            FUNC_DATA:   queue_byte(v, 1'b1, char_delay, 1'b1);
            default:
            begin
                queue_event(held_nibble, held_rs, 1'b0, POWERUP_HOLD, 1'b0);
                for (i = 0; i < 4; i++)
                begin
                    queue_strobe(WAKE_NIBBLES[(3-i)*4 +: 4], 1'b0,
                                 WAKE_HOLDS[(3-i)*16 +: 16], 1'b0);
                end
                for (i = 0; i < 5; i++)
                begin
                    queue_byte(SETUP_BYTES[(4-i)*8 +: 8], 1'b0,
                               SETUP_HOLDS[(4-i)*16 +: 16], i == 4);
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_event_t want;
        if (!rst_n)
        begin
            expected_events.delete();
            pulse_width    = PULSE_WIDTH_RESET;
            char_delay     = CHAR_DELAY_RESET;
            held_nibble    = 4'h0;
            held_rs        = 1'b0;
            pending_events <= 0;
            mismatch_count <= errors;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PULSE_WIDTH)
                    pulse_width = cfg_wdata[7:0];
                else if (cfg_index == REG_CHAR_DELAY)
                    char_delay = cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: pin event with none expected, expected nothing, actual %0h %0b %0b %0h %0b",
                             $time, nibble, rs, enable, hold_us, last);
                end
                else
                begin
                    want = expected_events.pop_front();
                    compare_field("nibble", {12'd0, want.nib}, {12'd0, nibble});
                    compare_field("rs", {15'd0, want.sel}, {15'd0, rs});
                    compare_field("enable", {15'd0, want.en}, {15'd0, enable});
                    compare_field("hold_us", want.hold, hold_us);
                    compare_field("last", {15'd0, want.fin}, {15'd0, last});
                end
            end
            if (in_valid && in_ready)
                predict_pin_events(func, value, delay_us);
            pending_events <= expected_events.size();
            mismatch_count <= errors;
        end
    end

endmodule

// File: tb/tb_lcd_4bit_bus_sequencer_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_lcd_4bit_bus_sequencer_core
// Drives LCD requests and register settings into the 4-bit bus sequencer
// under varying sender gaps and receiver stalls; a separate checker predicts
// and compares every pin event, and this module gives the verdict.
// ============================================================================
module tb_lcd_4bit_bus_sequencer_core;
    import lcdseq_pkg::*;

    // Register indexes with no register behind them; writes there must be
    // ignored by the block.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Generous bound: even a run made only of power-up sequences under the
    // heaviest stalls finishes in a small fraction of this.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_PHASE = 45;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            func      = FUNC_NIBBLE;
    logic [7:0]            value     = 8'h00;
    logic [15:0]           delay_us  = 16'h0000;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [3:0]            nibble;
    logic                  rs;
    logic                  enable;
    logic [15:0]           hold_us;
    logic                  last;

    int pending_events;
    int mismatch_count;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;

    lcd_4bit_bus_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .delay_us  (delay_us),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .nibble    (nibble),
        .rs        (rs),
        .enable    (enable),
        .hold_us   (hold_us),
        .last      (last)
    );

    lcd_pin_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .value          (value),
        .delay_us       (delay_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .nibble         (nibble),
        .rs             (rs),
        .enable         (enable),
        .hold_us        (hold_us),
        .last           (last),
        .pending_events (pending_events),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver stalls at random at the rate of the current phase. A rate
    // of zero keeps ready high throughout.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one item and returns at the edge where it is taken. Valid stays
    // high on return, so a following item can go out back to back; when the
    // sender decides to idle, valid drops first.
    task automatic send_request(input logic [1:0] f, input logic [7:0] v,
                                input logic [15:0] d);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        delay_us <= d;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random request: mostly commands and data with the power-up sequence
    // mixed in now and then. Delays lean toward the extremes.
    task automatic send_random_request();
        logic [1:0]  f;
        logic [15:0] d;
        if ($urandom_range(99) < 7)
            f = FUNC_INIT;
        else
        begin
            case ($urandom_range(2))
                0:       f = FUNC_NIBBLE;
                1:       f = FUNC_BYTE;
                default: f = FUNC_DATA;
            endcase
        end
        case ($urandom_range(7))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            default: d = 16'($urandom);
        endcase
        send_request(f, 8'($urandom), d);
    endtask

    // Stops offering items and waits until every predicted pin event has
    // come out. The first edge lets the checker count an item that was
    // taken at the current edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events != 0)
            @(posedge clk);
    endtask

    // Writes both registers and then one unused index. The pulse width write
    // carries random upper bits that the block must drop.
    task automatic configure(input logic [7:0] pulse, input logic [15:0] char_hold);
        logic [7:0] junk;
        junk = 8'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PULSE_WIDTH;
        cfg_wdata <= {junk, pulse};
        @(posedge clk);
        cfg_index <= REG_CHAR_DELAY;
        cfg_wdata <= char_hold;
        @(posedge clk);
        cfg_index <= ($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int n;
        int pause_at;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset settings. The power-up sequence goes
        // first, so its opening event must show the cleared pin levels.
        send_request(FUNC_INIT, 8'h00, 16'h0000);
        // A nibble command uses only the low four bits of the value.
        send_request(FUNC_NIBBLE, 8'hFF, 16'h0000);
        send_request(FUNC_NIBBLE, 8'h00, 16'hFFFF);
        send_request(FUNC_BYTE, 8'hFF, 16'hFFFF);
        send_request(FUNC_BYTE, 8'h00, 16'h0000);
        // Data bytes ignore the requested delay and use the character delay.
        send_request(FUNC_DATA, 8'hA5, 16'hFFFF);
        send_request(FUNC_DATA, 8'h5A, 16'h0000);
        // The power-up sequence after data opens with RS high and the last
        // data nibble still on the bus.
        send_request(FUNC_INIT, 8'hFF, 16'hFFFF);
        drain();

        // A zero pulse width is taken as written.
        configure(8'd0, 16'hFFFF);
        send_request(FUNC_DATA, 8'hFF, 16'h0000);
        send_request(FUNC_NIBBLE, 8'h0A, 16'h1234);
        send_request(FUNC_BYTE, 8'h3C, 16'h8000);
        send_request(FUNC_INIT, 8'h00, 16'h0000);
        drain();

        configure(8'd255, 16'd0);
        send_request(FUNC_DATA, 8'h00, 16'hFFFF);
        send_request(FUNC_NIBBLE, 8'h05, 16'h0001);
        send_request(FUNC_BYTE, 8'hC3, 16'h7FFF);
        send_request(FUNC_DATA, 8'h81, 16'h0000);
        drain();

        // Random part in four phases: no idling, sender gaps, receiver
        // stalls, then both. Each phase has its own register settings and
        // pauses once in the middle until every pin event has come out.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    configure(8'd255, 16'hFFFF);
                end
                1:
                begin
                    gap_pct   = 59;
                    stall_pct = 0;
                    configure(8'd0, 16'd0);
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 59;
                    configure(8'($urandom_range(254, 1)), 16'($urandom));
                end
                default:
                begin
                    gap_pct   = 24;
                    stall_pct = 24;
                    configure(PULSE_WIDTH_RESET, CHAR_DELAY_RESET);
                end
            endcase
            pause_at = $urandom_range(ITEMS_PER_PHASE - 5, 5);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == pause_at)
                    drain();
                send_random_request();
            end
            drain();
        end

        // Let the block settle so that any stray pin event still shows up.
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: lcd_4bit_bus_sequencer_core.f
rtl/lcdseq_pkg.sv
rtl/lcdseq_ctrl.sv
rtl/lcdseq_dp.sv
rtl/lcd_4bit_bus_sequencer_core.sv
tb/lcd_pin_event_checker.sv
tb/tb_lcd_4bit_bus_sequencer_core.sv
